// ===== rtl/rbfc_pkg.sv =====
package rbfc_pkg;
   localparam int MAX_CHANNELS_DEF = 4;
   localparam int MAX_DELAY_DEF    = 8;
   localparam int MAX_CENTERS_DEF  = 256;
   localparam int DIST_W           = 39;
   localparam int SAMPLE_W         = 16;
   localparam int SUM_W            = 32;
   localparam int COUNT_W          = 16;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 39;
   localparam int IDX_W            = 8;
   localparam int CCNT_W           = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CHANNELS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DELAY    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS       = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIST,
      ST_CMP,
      ST_DECIDE,
      ST_WRITE,
      ST_UPDATE,
      ST_OUT
   } state_type;
endpackage

// ===== rtl/rbf_center_clustering.sv =====
// nearest-neighbor center clustering for rbf training. samples enter one channel value
// per transaction on req_; after num_delay full time steps plus one target step, each
// completed pattern is compared against every stored center with a single shared
// subtract/square/accumulate unit, one pattern element per cycle through the registered
// read port of the center memory. a new center is then copied element by element, each
// read followed by a write, the target sums are read and written back per channel
// (saturating) and the window slide reads and writes each stored element in turn.
// samples that do not complete a pattern produce no response.
// req_tready is low from a completed pattern until the window slide after it ends; a
// response still waiting on rsp_ holds the next completed pattern at its output step.
module rbf_center_clustering
   import rbfc_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int MAX_DELAY    = MAX_DELAY_DEF,
   parameter int MAX_CENTERS  = MAX_CENTERS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,  // sample_value
   input  logic                  req_tuser,  // restart
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [79:0]           rsp_tdata   // cluster_index, member_count, center_count,
                                              // nearest_distance, zero fill
   ,output logic [1:0]           rsp_tuser   // new_center, table_full
);
   localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
   localparam int DL_W   = $clog2(MAX_DELAY + 2);
   localparam int CHI_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int WIN_D  = (MAX_DELAY + 1) * MAX_CHANNELS;
   localparam int WIN_W  = $clog2(WIN_D);
   localparam int PAT_L  = MAX_CHANNELS * MAX_DELAY;
   localparam int PAT_W  = $clog2(PAT_L + 1);
   localparam int CTR_W  = $clog2(MAX_CENTERS);
   localparam int CU_W   = $clog2(MAX_CENTERS + 1);
   localparam int CS_D   = MAX_CENTERS * PAT_L;
   localparam int CS_W   = $clog2(CS_D);
   localparam int TS_D   = MAX_CENTERS * MAX_CHANNELS;
   localparam int TS_W   = $clog2(TS_D);
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // configuration
   logic [2:0]        num_channels_ff;
   logic [3:0]        num_delay_ff;
   logic [DIST_W-1:0] radius_ff;

   // memories
   logic signed [SAMPLE_W-1:0] window_mem [WIN_D];
   logic signed [SAMPLE_W-1:0] center_mem [CS_D];
   logic signed [SUM_W-1:0]    sum_mem    [TS_D];
   logic [COUNT_W-1:0]         count_mem  [MAX_CENTERS];

   state_type state_ff, state_in;
   logic [CU_W-1:0]   used_ff, used_in;
   logic [CHI_W-1:0]  chpos_ff, chpos_in;
   logic [DL_W-1:0]   filled_ff, filled_in;
   logic [CTR_W-1:0]  ctr_ff, ctr_in;        // center under test
   logic [PAT_W-1:0]  elem_ff, elem_in;      // element within pattern
   logic [DIST_W-1:0] acc_ff, acc_in;
   logic [DIST_W-1:0] bestd_ff, bestd_in;
   logic [CTR_W-1:0]  best_ff, best_in;
   logic              rd_ok_ff, rd_ok_in;    // read data valid next cycle
   logic              isnew_ff, isnew_in;
   logic              full_ff, full_in;
   logic              shift_ff, shift_in;    // window slide in progress
   logic [WIN_W:0]    sh_ff, sh_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [COUNT_W-1:0] mcnt_ff;
   logic [79:0]       rsp_data_ff;
   logic [1:0]        rsp_user_ff;
   logic              rsp_valid_ff;

   // effective geometry
   logic [CH_W-1:0] nc;
   logic [DL_W-1:0] nd;
   always_comb begin
      if (num_channels_ff == 3'd0) nc = CH_W'(1);
      else if (32'(num_channels_ff) > MAX_CHANNELS) nc = CH_W'(MAX_CHANNELS);
      else nc = CH_W'(num_channels_ff);
      if (num_delay_ff == 4'd0) nd = DL_W'(1);
      else if (32'(num_delay_ff) > MAX_DELAY) nd = DL_W'(MAX_DELAY);
      else nd = DL_W'(num_delay_ff);
   end

   // element index -> step t and channel c (channel fastest)
   logic [PAT_W-1:0] elem_t;
   logic [CHI_W-1:0] elem_c;
   logic [PAT_W-1:0] pat_len;
   assign pat_len = PAT_W'(nc) * PAT_W'(nd);
   // step/channel counters kept alongside elem to avoid division
   logic [DL_W-1:0]  et_ff, et_in;
   logic [CHI_W-1:0] ec_ff, ec_in;
   assign elem_t = PAT_W'(et_ff);
   assign elem_c = ec_ff;

   logic [WIN_W-1:0] win_addr;
   logic [CS_W-1:0]  cs_addr;
   assign win_addr = WIN_W'(32'(elem_t) * MAX_CHANNELS + 32'(elem_c));
   assign cs_addr  = CS_W'(32'(ctr_ff) * PAT_L + 32'(elem_t) * MAX_CHANNELS
                     + 32'(elem_c));

   // window slide addresses
   logic [WIN_W-1:0] sh_dst;
   assign sh_dst = WIN_W'(sh_ff);
   logic [WIN_W-1:0] sh_src;
   assign sh_src = WIN_W'(32'(sh_ff) + MAX_CHANNELS);

   // registered memory reads
   logic signed [SAMPLE_W-1:0] p_rd_ff, q_rd_ff, t_rd_ff;
   logic signed [SUM_W-1:0]    s_rd_ff;
   logic [COUNT_W-1:0]         c_rd_ff;
   logic [WIN_W-1:0]           tgt_addr;
   logic [TS_W-1:0]            ts_addr;
   // second window port serves the target step, or the slide source while sliding
   assign tgt_addr = shift_ff ? sh_src : WIN_W'(32'(nd) * MAX_CHANNELS + 32'(ec_ff));
   assign ts_addr  = TS_W'(32'(idx_ff) * MAX_CHANNELS + 32'(ec_ff));

   always_ff @(posedge clock) begin
      p_rd_ff <= window_mem[win_addr];
      q_rd_ff <= center_mem[cs_addr];
      t_rd_ff <= window_mem[tgt_addr];
      s_rd_ff <= sum_mem[ts_addr];
      c_rd_ff <= count_mem[CTR_W'(idx_ff)];
   end

   // shared difference-square unit
   logic signed [SAMPLE_W:0]   diff;
   logic [2*SAMPLE_W+1:0]      sq;
   logic [DIST_W:0]            acc_sum;
   assign diff    = (SAMPLE_W+1)'(p_rd_ff) - (SAMPLE_W+1)'(q_rd_ff);
   assign sq      = (2*SAMPLE_W+2)'(diff * diff);
   assign acc_sum = (DIST_W+1)'(acc_ff) + (DIST_W+1)'(sq);

   logic signed [SUM_W:0] ssum;
   assign ssum = (SUM_W+1)'(s_rd_ff) + (SUM_W+1)'(t_rd_ff);

   logic accept, clear, last_ch;
   assign accept = req_tvalid && req_tready;
   assign clear  = (csr_we && (csr_index == CSR_NUM_CHANNELS || csr_index == CSR_NUM_DELAY));

   // clamp stale position counters on each sample
   logic [CHI_W-1:0] cp_eff;
   logic [DL_W-1:0]  sf_eff;
   always_comb begin
      cp_eff = (32'(chpos_ff) >= 32'(nc)) ? '0 : chpos_ff;
      sf_eff = (filled_ff > nd) ? nd : filled_ff;
      if (req_tuser) begin
         cp_eff = '0;
         sf_eff = '0;
      end
   end
   assign last_ch = (32'(cp_eff) + 1 >= 32'(nc));

   logic last_elem;
   assign last_elem = (32'(elem_ff) + 1 == 32'(pat_len));

   always_comb begin
      state_in  = state_ff;
      used_in   = used_ff;
      chpos_in  = chpos_ff;
      filled_in = filled_ff;
      ctr_in    = ctr_ff;
      elem_in   = elem_ff;
      et_in     = et_ff;
      ec_in     = ec_ff;
      acc_in    = acc_ff;
      bestd_in  = bestd_ff;
      best_in   = best_ff;
      rd_ok_in  = 1'b0;
      isnew_in  = isnew_ff;
      full_in   = full_ff;
      shift_in  = shift_ff;
      sh_in     = sh_ff;
      idx_in    = idx_ff;
      req_tready = (state_ff == ST_IDLE) && !shift_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (shift_ff) begin
               // slide window one step: read one element, write it in the following cycle
               if (rd_ok_ff) begin
                  if (32'(sh_ff) + 1 >= 32'(nd) * MAX_CHANNELS) shift_in = 1'b0;
                  sh_in = sh_ff + 1'b1;
               end else rd_ok_in = 1'b1;
            end else if (accept) begin
               if (req_tuser) used_in = '0;
               if (!last_ch) begin
                  chpos_in  = cp_eff + 1'b1;
                  filled_in = sf_eff;
               end else if (sf_eff < nd) begin
                  chpos_in  = '0;
                  filled_in = sf_eff + 1'b1;
               end else begin
                  chpos_in  = '0;
                  filled_in = sf_eff;
                  ctr_in = '0; elem_in = '0; et_in = '0; ec_in = '0;
                  acc_in = '0; bestd_in = '0; best_in = '0;
                  isnew_in = 1'b0; full_in = 1'b0;
                  if (req_tuser || used_ff == '0) begin
                     isnew_in = 1'b1;
                     idx_in   = '0;
                     state_in = ST_WRITE;
                  end else begin
                     state_in = ST_DIST;
                  end
               end
            end
         end
         ST_DIST: begin
            // issue one element read per cycle; its data is accumulated in the following cycle
            if (rd_ok_ff) acc_in = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];
            if (32'(elem_ff) < 32'(pat_len)) begin
               elem_in = elem_ff + 1'b1;
               if (32'(ec_ff) + 1 >= 32'(nc)) begin
                  ec_in = '0; et_in = et_ff + 1'b1;
               end else ec_in = ec_ff + 1'b1;
               rd_ok_in = 1'b1;
            end else state_in = ST_CMP;
         end
         ST_CMP: begin
            if (ctr_ff == '0 || acc_ff < bestd_ff) begin
               bestd_in = acc_ff; best_in = ctr_ff;
            end
            acc_in = '0; elem_in = '0; et_in = '0; ec_in = '0;
            if (32'(ctr_ff) + 1 < 32'(used_ff)) begin
               ctr_in = ctr_ff + 1'b1;
               rd_ok_in = 1'b0;
               state_in = ST_DIST;
            end else state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (bestd_ff < radius_ff) begin
               idx_in = IDX_W'(best_ff);
               ec_in = '0; state_in = ST_UPDATE;
            end else if (32'(used_ff) < MAX_CENTERS) begin
               idx_in = IDX_W'(used_ff); isnew_in = 1'b1;
               ctr_in = CTR_W'(used_ff);
               elem_in = '0; et_in = '0; ec_in = '0;
               state_in = ST_WRITE;
            end else begin
               idx_in = IDX_W'(best_ff); full_in = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_WRITE: begin
            // copy pattern into the new center: read first, then write in the following cycle
            if (rd_ok_ff) begin
               if (last_elem) begin
                  ec_in = '0; state_in = ST_UPDATE;
               end else begin
                  elem_in = elem_ff + 1'b1;
                  if (32'(ec_ff) + 1 >= 32'(nc)) begin
                     ec_in = '0; et_in = et_ff + 1'b1;
                  end else ec_in = ec_ff + 1'b1;
               end
            end else begin
               ctr_in = CTR_W'(idx_ff);
               rd_ok_in = 1'b1;
            end
         end
         ST_UPDATE: begin
            // per-channel target sum write; reads are registered, so each channel is read before it is written
            if (rd_ok_ff) begin
               if (full_ff) state_in = ST_OUT;
               else if (32'(ec_ff) + 1 >= 32'(nc)) begin
                  if (isnew_ff) used_in = used_ff + 1'b1;
                  state_in = ST_OUT;
               end else ec_in = ec_ff + 1'b1;
            end else rd_ok_in = 1'b1;
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               shift_in = 1'b1; sh_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (clear) begin
         used_in = '0; chpos_in = '0; filled_in = '0;
      end
   end

   // window, center and sum stores
   logic [WIN_W-1:0] wr_win;
   assign wr_win = WIN_W'(32'(sf_eff) * MAX_CHANNELS + 32'(cp_eff));

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && !shift_ff && accept) window_mem[wr_win] <= req_tdata;
      if (state_ff == ST_IDLE && shift_ff && rd_ok_ff) window_mem[sh_dst] <= t_rd_ff;
      if (state_ff == ST_WRITE && rd_ok_ff) center_mem[cs_addr] <= p_rd_ff;
      if (state_ff == ST_UPDATE && rd_ok_ff && !full_ff)
         sum_mem[ts_addr] <= isnew_ff ? SUM_W'(t_rd_ff) :
            (ssum[SUM_W] != ssum[SUM_W-1]) ?
               (ssum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}}) :
               ssum[SUM_W-1:0];
      if (state_ff == ST_UPDATE && rd_ok_ff && !full_ff && 32'(ec_ff) + 1 >= 32'(nc))
         count_mem[CTR_W'(idx_ff)] <= isnew_ff ? COUNT_W'(1) :
            ((c_rd_ff == {COUNT_W{1'b1}}) ? c_rd_ff : c_rd_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE && rd_ok_ff && !full_ff && 32'(ec_ff) + 1 >= 32'(nc))
         mcnt_ff <= isnew_ff ? COUNT_W'(1) :
            ((c_rd_ff == {COUNT_W{1'b1}}) ? c_rd_ff : c_rd_ff + 1'b1);
      else if (state_ff == ST_UPDATE && rd_ok_ff && full_ff) mcnt_ff <= c_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; used_ff <= '0; chpos_ff <= '0; filled_ff <= '0;
         rd_ok_ff <= 1'b0; shift_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         num_channels_ff <= 3'd1; num_delay_ff <= 4'd1; radius_ff <= DIST_W'(13107);
      end else begin
         state_ff <= state_in; used_ff <= used_in; chpos_ff <= chpos_in;
         filled_ff <= filled_in; rd_ok_ff <= rd_ok_in; shift_ff <= shift_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_NUM_CHANNELS: num_channels_ff <= csr_wdata[2:0];
               CSR_NUM_DELAY:    num_delay_ff    <= csr_wdata[3:0];
               CSR_RADIUS:       radius_ff       <= csr_wdata[DIST_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_OUT && !rsp_valid_ff) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ctr_ff <= ctr_in; elem_ff <= elem_in; et_ff <= et_in; ec_ff <= ec_in;
      acc_ff <= acc_in; bestd_ff <= bestd_in; best_ff <= best_in;
      isnew_ff <= isnew_in; full_ff <= full_in;
      sh_ff <= sh_in; idx_ff <= idx_in;
      if (state_ff == ST_OUT && !rsp_valid_ff) begin
         rsp_data_ff <= {8'd0, bestd_ff, CCNT_W'(used_ff), mcnt_ff, idx_ff};
         rsp_user_ff <= {full_ff, isnew_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule

// ===== rtl/rbfc_checker.sv =====
module rbfc_checker
   import rbfc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp stalled payload changed");
   a_new_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("new center and full together");
   a_new_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[23:8] == 16'd1)
      else $error("new center count not one");
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");
endmodule

bind rbf_center_clustering rbfc_checker u_rbfc_checker (.*);
